>>> src/setq_pkg.sv
// Shared types and constants for the sorted event time queue.
package setq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 48;
    localparam int TAG_W   = 32;
    localparam int RXN_W   = 8;
    localparam int MOL_W   = 16;
    localparam int PAY_W   = RXN_W + 2 * MOL_W + 1;
    localparam int ENTRY_W = KEY_W + TAG_W + PAY_W;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;
    localparam int OCC_W   = 7;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 128;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_POP_WAIT,
        S_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic ins_start;
        logic ins_rd;
        logic ins_shift;
        logic ins_place;
        logic pop_rd;
        logic pop_take;
        logic res_full;
        logic res_empty;
        logic clear;
        logic emit;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic key_gt;
        logic m_busy;
    } stat_t;

    typedef struct packed {
        status_t            status;
        logic [MOL_W-1:0]   second;
        logic [MOL_W-1:0]   first;
        logic [RXN_W-1:0]   reaction;
        logic [TAG_W-1:0]   tag;
        logic [KEY_W-1:0]   key;
        logic               background;
    } result_t;

endpackage

>>> src/sorted_event_time_queue_core.sv
// Sorted event time queue: top level joining controller and datapath.
//
// Holds up to 64 pending reaction events in ascending order of a 48-bit time
// key; equal keys leave in arrival order. Each beat on the slave side carries
// one command in s_tuser (insert, pop earliest, clear; the fourth code does
// nothing) and, for an insert, the event in s_tdata. Every command returns
// exactly one beat on the master side: the status in m_tuser and the popped
// event, the tag given to an insert, and the occupancy after the command in
// m_tdata. Events live in a single-port-read, single-port-write memory used
// as a ring, so a pop only moves the head. An insert walks back from the
// tail, moving each later event up one slot; that walk is bounded by the one
// memory read port, with a read and a compare state for each moved event.
// One command is handled at a time. The next command is taken while a
// finished result still waits in the output register.
module sorted_event_time_queue_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: event_time[47:0], reaction_id[55:48], first_molecule[71:56],
    //          second_molecule[87:72], background_flag[88], zero fill [95:89]
    input  logic [setq_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [setq_pkg::OP_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: out_time[47:0], out_tag[79:48], out_reaction[87:80],
    //          out_first[103:88], out_second[119:104], out_background[120],
    //          occupancy[127:121]
    output logic [setq_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [setq_pkg::STS_W-1:0]     m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import setq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence the commands one at a time.
    setq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op_in    (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Hold the events, counters and the result beat.
    setq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> src/setq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module setq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/setq_ctrl.sv
// Controller state machine for the sorted event time queue.
module setq_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic [setq_pkg::OP_W-1:0]  op_in,
    input  setq_pkg::stat_t            stat,
    output logic                       s_tready,
    output setq_pkg::cmd_t             cmd
);
    import setq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (op_t'(op_in))
                        OP_INSERT: state_next = stat.full ? S_DONE : S_INS_RD;
                        OP_POP:    state_next = stat.empty ? S_DONE : S_POP_WAIT;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_INS_RD:   state_next = stat.idx_zero ? S_DONE : S_INS_CMP;
            S_INS_CMP:  state_next = stat.key_gt ? S_INS_RD : S_DONE;
            S_POP_WAIT: state_next = S_DONE;
            S_DONE:     state_next = stat.m_busy ? S_DONE : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    case (op_t'(op_in))
                        OP_INSERT: begin
                            cmd.res_full  = stat.full;
                            cmd.ins_start = !stat.full;
                        end
                        OP_POP: begin
                            cmd.res_empty = stat.empty;
                            cmd.pop_rd    = !stat.empty;
                        end
                        OP_CLEAR: cmd.clear = 1'b1;
                        // Unused code: answer with an ok beat whose event fields are zero.
                        default:  ;
                    endcase
                end
            end
            S_INS_RD: begin
                cmd.ins_place = stat.idx_zero;
                cmd.ins_rd    = !stat.idx_zero;
            end
            S_INS_CMP: begin
                cmd.ins_shift = stat.key_gt;
                cmd.ins_place = !stat.key_gt;
            end
            S_POP_WAIT: cmd.pop_take = 1'b1;
            S_DONE:     cmd.emit     = !stat.m_busy;
            default:    cmd          = '0;
        endcase
    end

endmodule

>>> src/setq_datapath.sv
// Datapath: event memory as a ring, counters, insert walk and result registers.
module setq_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  setq_pkg::cmd_t                 cmd,
    output setq_pkg::stat_t                stat,
    input  logic [setq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [setq_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [setq_pkg::STS_W-1:0]     m_tuser
);
    import setq_pkg::*;

    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               m_valid_reg, m_valid_next;

    logic [KEY_W-1:0]   key_reg;
    logic [PAY_W-1:0]   pay_reg;
    result_t            res_reg;
    result_t            res_init;
    result_t            out_reg;
    logic [OCC_W-1:0]   occ_reg;

    logic [CNT_W-1:0]   idx_m1;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [KEY_W-1:0]   rd_key;
    logic [TAG_W-1:0]   rd_tag;
    logic [PAY_W-1:0]   rd_pay;

    assign idx_m1 = idx_reg - 1'b1;
    assign {rd_key, rd_tag, rd_pay} = rd_data;

    // Physical slot = head + logical position, wrapping over the ring.
    assign wr_en   = cmd.ins_shift | cmd.ins_place;
    assign wr_addr = head_reg + idx_reg[ADDR_W-1:0];
    assign wr_data = cmd.ins_shift ? rd_data : {key_reg, tag_reg, pay_reg};
    assign rd_en   = cmd.ins_rd | cmd.pop_rd;
    assign rd_addr = cmd.pop_rd ? head_reg : ADDR_W'(head_reg + idx_m1[ADDR_W-1:0]);

    setq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.key_gt   = (rd_key > key_reg);
    assign stat.m_busy   = m_valid_reg & ~m_tready;

    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        tag_next     = tag_reg;
        m_valid_next = m_valid_reg;
        if (cmd.ins_start) begin
            idx_next = count_reg;
        end
        if (cmd.ins_shift) begin
            idx_next = idx_m1;
        end
        if (cmd.ins_place) begin
            count_next = count_reg + 1'b1;
            tag_next   = tag_reg + 1'b1;
        end
        if (cmd.pop_take) begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.clear) begin
            count_next = '0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            tag_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            tag_reg     <= tag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Start each result from zero, flagging a dropped insert or an empty pop.
    always_comb begin
        res_init = '0;
        if (cmd.res_full) begin
            res_init.status = STS_FULL;
        end else if (cmd.res_empty) begin
            res_init.status = STS_EMPTY;
        end
    end

    // Input latch, pending result and output register.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            key_reg <= s_tdata[KEY_W-1:0];
            pay_reg <= {s_tdata[55:48], s_tdata[71:56], s_tdata[87:72], s_tdata[88]};
            res_reg <= res_init;
        end
        if (cmd.ins_place) begin
            res_reg.tag <= tag_reg;
        end
        if (cmd.pop_take) begin
            res_reg.key        <= rd_key;
            res_reg.tag        <= rd_tag;
            res_reg.reaction   <= rd_pay[PAY_W-1 -: RXN_W];
            res_reg.first      <= rd_pay[2*MOL_W:MOL_W+1];
            res_reg.second     <= rd_pay[MOL_W:1];
            res_reg.background <= rd_pay[0];
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
            occ_reg <= OCC_W'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {occ_reg, out_reg.background, out_reg.second, out_reg.first,
                       out_reg.reaction, out_reg.tag, out_reg.key};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_place |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)) &&
                          (tag_reg == TAG_W'($past(tag_reg) + 1'b1)))
        else $error("insert did not advance count and tag");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_take |=> head_reg == ADDR_W'($past(head_reg) + 1'b1))
        else $error("pop did not advance head");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_tready))
        else $error("result overwritten while stalled");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the sorted event time queue core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import setq_pkg::*;

    // The fourth command code does nothing; it has no name in the package.
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int DRAIN_CYCLES  = 160;
    localparam int STALL_LIMIT   = 5000;  // cycles with no beat on either side

    // One command as driven on the slave side.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [RXN_W-1:0] rxn;
        logic [MOL_W-1:0] mol_a;
        logic [MOL_W-1:0] mol_b;
        logic             bg;
    } evt_cmd_t;

    // One stored event.
    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [RXN_W-1:0] rxn;
        logic [MOL_W-1:0] mol_a;
        logic [MOL_W-1:0] mol_b;
        logic             bg;
    } evt_entry_t;

    // One master-side result, unpacked.
    typedef struct {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [RXN_W-1:0] rxn;
        logic [MOL_W-1:0] mol_a;
        logic [MOL_W-1:0] mol_b;
        logic             bg;
        logic [OCC_W-1:0] occ;
    } evt_result_t;

    // Directed row: a command, and where obvious, its status, tag and occupancy.
    typedef struct {
        evt_cmd_t         cmd;
        bit               typed;
        status_t          sts;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occ;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = OP_INSERT;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STS_W-1:0]      m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // Shadow of the queue contents, ordered by key then arrival.
    evt_entry_t            shadow_events[DEPTH];
    int unsigned           shadow_count = 0;
    logic [TAG_W-1:0]      shadow_next_tag = '0;

    evt_result_t           queue_answers[$];   // results owed by the block, oldest first
    dir_row_t              dir_rows[$];

    // Typed expectation of the beat currently offered; read at acceptance.
    bit                    beat_typed = 1'b0;
    evt_result_t           beat_typed_result;

    int unsigned           idle_pct = 0;
    int unsigned           stall_pct = 0;
    int unsigned           fails = 0;
    int unsigned           quiet_cycles = 0;

    int unsigned           n_insert = 0, n_pop = 0, n_clear = 0, n_nop = 0;
    int unsigned           n_full_drop = 0, n_empty_pop = 0, peak_occ = 0;

    logic [KEY_W-1:0]      last_key = '0;
    bit                    fill_mode = 1'b1;

    sorted_event_time_queue_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #2 aclk = ~aclk;

    // Apply one accepted command to the shadow queue and return the result it owes.
    function automatic evt_result_t event_queue_step(input evt_cmd_t c);
        evt_result_t r;
        int unsigned pos;
        r = '{status: STS_OK, default: '0};
        case (c.op)
            OP_INSERT: begin
                n_insert++;
                if (shadow_count >= DEPTH) begin
                    r.status = STS_FULL;
                    n_full_drop++;
                end else begin
                    // Land after every held key that is less than or equal.
                    pos = 0;
                    while (pos < shadow_count && shadow_events[pos].key <= c.key)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_events[i] = shadow_events[i-1];
                    shadow_events[pos] = '{c.key, shadow_next_tag, c.rxn,
                                           c.mol_a, c.mol_b, c.bg};
                    shadow_count++;
                    r.tag = shadow_next_tag;
                    shadow_next_tag = shadow_next_tag + 1'b1;
                end
            end
            OP_POP: begin
                n_pop++;
                if (shadow_count == 0) begin
                    r.status = STS_EMPTY;
                    n_empty_pop++;
                end else begin
                    r.key   = shadow_events[0].key;
                    r.tag   = shadow_events[0].tag;
                    r.rxn   = shadow_events[0].rxn;
                    r.mol_a = shadow_events[0].mol_a;
                    r.mol_b = shadow_events[0].mol_b;
                    r.bg    = shadow_events[0].bg;
                    for (int i = 1; i < shadow_count; i++)
                        shadow_events[i-1] = shadow_events[i];
                    shadow_count--;
                end
            end
            OP_CLEAR: begin
                n_clear++;
                shadow_count = 0;   // tag counter survives a clear
            end
            default: n_nop++;
        endcase
        if (shadow_count > peak_occ)
            peak_occ = shadow_count;
        r.occ = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void field_check(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    // Score the output beat, then predict the input beat, at every rising edge.
    always @(posedge aclk) begin
        evt_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.key    = m_tdata[47:0];
            got.tag    = m_tdata[79:48];
            got.rxn    = m_tdata[87:80];
            got.mol_a  = m_tdata[103:88];
            got.mol_b  = m_tdata[119:104];
            got.bg     = m_tdata[120];
            got.occ    = m_tdata[127:121];
            if (queue_answers.size() == 0) begin
                $error("result beat with no command outstanding");
                fails++;
            end else begin
                want = queue_answers.pop_front();
                field_check("status",         64'(want.status), 64'(got.status));
                field_check("out_time",       64'(want.key),    64'(got.key));
                field_check("out_tag",        64'(want.tag),    64'(got.tag));
                field_check("out_reaction",   64'(want.rxn),    64'(got.rxn));
                field_check("out_first",      64'(want.mol_a),  64'(got.mol_a));
                field_check("out_second",     64'(want.mol_b),  64'(got.mol_b));
                field_check("out_background", 64'(want.bg),     64'(got.bg));
                field_check("occupancy",      64'(want.occ),    64'(got.occ));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            want = event_queue_step('{s_tuser, s_tdata[47:0], s_tdata[55:48],
                                      s_tdata[71:56], s_tdata[87:72], s_tdata[88]});
            // Directed rows with a hand-written answer override the shadow.
            queue_answers.insert(queue_answers.size(),
                                 beat_typed ? beat_typed_result : want);
        end
    end

    // Throttle the result side.
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Abort when neither side has moved a beat for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one command, idling at random first, and hold until it is taken.
    task automatic send_cmd(input evt_cmd_t c, input bit typed, input evt_result_t typed_res);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            s_tuser  <= OP_W'($urandom_range(0, 3));
            @(negedge aclk);
        end
        beat_typed        = typed;
        beat_typed_result = typed_res;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, c.bg, c.mol_b, c.mol_a, c.rxn, c.key};
        s_tuser  <= c.op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (queue_answers.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                    input logic [RXN_W-1:0] rxn, input logic [MOL_W-1:0] ma,
                                    input logic [MOL_W-1:0] mb, input logic bg,
                                    input bit typed, input status_t sts,
                                    input logic [TAG_W-1:0] tag, input logic [OCC_W-1:0] occ);
        dir_row_t row;
        row.cmd   = '{op, key, rxn, ma, mb, bg};
        row.typed = typed;
        row.sts   = sts;
        row.tag   = tag;
        row.occ   = occ;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Build one random command, steering between filling and draining the queue.
    function automatic evt_cmd_t next_random_cmd();
        evt_cmd_t c;
        int unsigned r;
        if (fill_mode && shadow_count >= DEPTH && $urandom_range(0, 1) == 1)
            fill_mode = 1'b0;
        else if (!fill_mode && shadow_count == 0 && $urandom_range(0, 1) == 1)
            fill_mode = 1'b1;
        else if (!fill_mode && $urandom_range(0, 99) < 2)
            fill_mode = 1'b1;
        r = $urandom_range(0, 999);
        if (fill_mode)
            c.op = (r < 20) ? OP_NOP : (r < 960) ? OP_INSERT : OP_POP;
        else
            c.op = (r < 10) ? OP_CLEAR : (r < 30) ? OP_NOP : (r < 900) ? OP_POP : OP_INSERT;
        // Favor repeated and tiny keys so equal-key ordering gets exercised.
        case ($urandom_range(0, 9))
            0:       c.key = '0;
            1:       c.key = '1;
            2, 3:    c.key = last_key;
            4, 5, 6: c.key = KEY_W'($urandom_range(0, 15));
            default: c.key = KEY_W'({$urandom, $urandom});
        endcase
        last_key = c.key;
        c.rxn   = RXN_W'($urandom_range(0, 255));
        c.mol_a = MOL_W'($urandom);
        c.bg    = 1'($urandom_range(0, 1));
        c.mol_b = (c.bg && $urandom_range(0, 1) == 1) ? c.mol_a : MOL_W'($urandom);
        return c;
    endfunction

    initial begin
        evt_result_t tr;
        evt_cmd_t    c;
        int unsigned sent;

        // Directed part: extremes, every command, equal keys, clear keeping tags.
        //      op         key                 rxn    first    second   bg typed sts  tag occ
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 1, STS_EMPTY, 0, 0);
        add_row(OP_NOP,    '1,                 8'hFF, 16'hFFFF,16'hFFFF,1, 1, STS_OK,    0, 0);
        add_row(OP_INSERT, 48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF,16'hFFFF,1, 1, STS_OK,    0, 1);
        add_row(OP_INSERT, 48'h0,              8'h00, 16'h0000,16'h0000,0, 1, STS_OK,    1, 2);
        add_row(OP_INSERT, 48'd1000,           8'h05, 16'h1234,16'h5678,0, 1, STS_OK,    2, 3);
        add_row(OP_INSERT, 48'd1000,           8'hA5, 16'h8001,16'h7FFE,0, 1, STS_OK,    3, 4);
        add_row(OP_INSERT, 48'd1000,           8'h5A, 16'h00FF,16'h00FF,1, 1, STS_OK,    4, 5);
        add_row(OP_NOP,    48'd77,             8'h11, 16'h2222,16'h3333,0, 1, STS_OK,    0, 5);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 1, STS_EMPTY, 0, 0);
        add_row(OP_INSERT, 48'h8000_0000_0000, 8'h80, 16'h8000,16'h0001,0, 1, STS_OK,    5, 1);
        add_row(OP_INSERT, 48'h7FFF_FFFF_FFFF, 8'h7F, 16'h7FFF,16'hFFFE,1, 1, STS_OK,    6, 2);
        add_row(OP_CLEAR,  '1,                 8'hFF, 16'hFFFF,16'hFFFF,1, 1, STS_OK,    0, 0);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 1, STS_EMPTY, 0, 0);
        add_row(OP_INSERT, 48'd42,             8'h2A, 16'hBEEF,16'hCAFE,0, 1, STS_OK,    7, 1);
        add_row(OP_POP,    '0,                 8'd0,  16'd0,   16'd0,   0, 0, STS_OK,    0, 0);
        add_row(OP_CLEAR,  '0,                 8'd0,  16'd0,   16'd0,   0, 1, STS_OK,    0, 0);

        // Hold reset, then release it away from the sampling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            tr = '{status: dir_rows[i].sts, tag: dir_rows[i].tag, occ: dir_rows[i].occ,
                   default: '0};
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, tr);
        end

        // Let the block go fully quiet before the random phases.
        drain_results();

        // Random part in four phases: no idling, sender gaps, receiver stalls, both.
        tr = '{status: STS_OK, default: '0};
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 11 : 0;
            stall_pct = (ph == 2) ? 53 : (ph == 3) ? 11 : 0;
            while (sent < PHASE_ITEMS * (ph + 1)) begin
                c = next_random_cmd();
                send_cmd(c, 1'b0, tr);
                if (c.op != OP_NOP)   // ignored codes don't count toward the total
                    sent++;
            end
            drain_results();
        end

        // Watch for stray beats after the last owed result.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (queue_answers.size() != 0) begin
            $error("%0d results never arrived", queue_answers.size());
            fails++;
        end

        $display("tb: ran %0d inserts (%0d dropped full), %0d pops (%0d on empty), %0d clears,",
                 n_insert, n_full_drop, n_pop, n_empty_pop, n_clear);
        $display("tb: %0d no-op codes, peak occupancy %0d of %0d, under four idle patterns",
                 n_nop, peak_occ, DEPTH);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sorted_event_time_queue_core.f
src/setq_pkg.sv
src/setq_ram.sv
src/setq_ctrl.sv
src/setq_datapath.sv
src/sorted_event_time_queue_core.sv
sim/tb.sv
